// ===== src/ats_pkg.sv =====
package ats_pkg;

  // Table geometry.
  localparam int MAX_TASKS   = 32;
  localparam int TASK_BITS   = 5;
  localparam int COUNT_BITS  = 6;
  localparam int MAX_THREADS = 64;
  localparam int THREAD_BITS = 6;
  localparam int EPOCH_BITS  = 16;
  localparam int PRI_BITS    = 8;
  localparam int KEY_BITS    = PRI_BITS + TASK_BITS;

  // Command codes.
  localparam logic [2:0] CMD_ADD       = 3'd0;
  localparam logic [2:0] CMD_DISP_OK   = 3'd1;
  localparam logic [2:0] CMD_DISP_FAIL = 3'd2;
  localparam logic [2:0] CMD_TRACK     = 3'd3;
  localparam logic [2:0] CMD_FINISH    = 3'd4;
  localparam logic [2:0] CMD_LIST      = 3'd5;

  // Task state codes.
  localparam logic [1:0] TS_READY    = 2'd0;
  localparam logic [1:0] TS_RUNNING  = 2'd1;
  localparam logic [1:0] TS_FINISHED = 2'd2;
  localparam logic [1:0] TS_STARVED  = 2'd3;

  localparam logic [PRI_BITS-1:0] PRI_MAX      = '1;
  localparam logic [PRI_BITS-1:0] THRESH_RESET = 8'd3;

  // Sort key: higher priority first, then lower id.
  typedef logic [KEY_BITS-1:0] key_t;

  typedef struct packed {
    logic [2:0]             cmd;
    logic [TASK_BITS-1:0]   task_id;
    logic [THREAD_BITS-1:0] thread_id;
    logic [EPOCH_BITS-1:0]  total_epochs;
  } in_item_t;

  typedef struct packed {
    logic [TASK_BITS-1:0] result_task;
    logic [1:0]           task_state;
    logic [PRI_BITS-1:0]  priority_now;
    logic [PRI_BITS-1:0]  rejections_now;
    logic                 all_done;
    logic                 starved_present;
    logic [TASK_BITS-1:0] starved_head;
    logic                 entry_valid;
    logic                 last;
  } out_item_t;

  // Control of the shared key comparator.
  typedef struct packed {
    logic eligible;
    logic first;
    logic have;
  } sel_ctrl_t;

endpackage

// ===== src/aging_task_scheduler_table_core.sv =====
// Channel | Direction | Handshake          | Payload
// in      | input     | in_valid, in_stall | in_item  (ats_pkg::in_item_t)
// out     | output    | out_valid, out_stall | out_item (ats_pkg::out_item_t)
// cfg     | input     | cfg_we             | cfg_wdata (starve threshold)
//
// A non-list command passes through accept (S_IDLE), table update (S_EXEC) and result (S_EMIT).
// A successful dispatch of a task in the starved list adds a walk over the list entries (S_FIFO).
// A list command first counts the ready tasks (S_COUNT), then selects each
// ready task in turn with one shared key comparator (S_SCAN, then S_EMIT).
// Reset (rst, synchronous) empties the table and the starved list.
// in_stall is high while an item is in work; a stalled result holds the sequencer.
module aging_task_scheduler_table_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  input  ats_pkg::in_item_t   in_item,
  output logic                out_valid,
  input  logic                out_stall,
  output ats_pkg::out_item_t  out_item,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_wdata
);

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_EXEC  = 3'd1;
  localparam logic [2:0] S_FIFO  = 3'd2;
  localparam logic [2:0] S_COUNT = 3'd3;
  localparam logic [2:0] S_SCAN  = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;

  logic [2:0] state;

  // Captured item.
  logic [2:0]                          cmd_r;
  logic [ats_pkg::TASK_BITS-1:0]       id_r;
  logic [ats_pkg::THREAD_BITS-1:0]     tid_r;
  logic [ats_pkg::EPOCH_BITS-1:0]      tot_r;
  logic [ats_pkg::PRI_BITS-1:0]        threshold;

  // Per-task tables.
  logic [1:0]                          ts_tab   [ats_pkg::MAX_TASKS];
  logic [ats_pkg::PRI_BITS-1:0]        pri_tab  [ats_pkg::MAX_TASKS];
  logic [ats_pkg::PRI_BITS-1:0]        rej_tab  [ats_pkg::MAX_TASKS];
  logic [ats_pkg::EPOCH_BITS-1:0]      ep_tab   [ats_pkg::MAX_TASKS];
  logic [ats_pkg::EPOCH_BITS-1:0]      tot_tab  [ats_pkg::MAX_TASKS];
  logic [ats_pkg::MAX_THREADS-1:0]     mask_tab [ats_pkg::MAX_TASKS];
  logic [ats_pkg::MAX_TASKS-1:0]       in_fifo;
  logic [ats_pkg::COUNT_BITS-1:0]      tasks_added;
  logic [ats_pkg::COUNT_BITS-1:0]      unfinished;

  // Starved list, with its oldest entry mirrored in a register.
  logic [ats_pkg::TASK_BITS-1:0]       fifo [ats_pkg::MAX_TASKS];
  logic [ats_pkg::COUNT_BITS-1:0]      fifo_cnt;
  logic [ats_pkg::TASK_BITS-1:0]       head;

  // Sequencer working registers.
  logic [ats_pkg::COUNT_BITS-1:0]      scan_i;
  logic [ats_pkg::COUNT_BITS-1:0]      ready_cnt;
  logic                                found;
  logic [ats_pkg::TASK_BITS-1:0]       res_id;
  logic                                res_valid;
  logic                                res_last;
  logic                                list_mode;
  logic                                first;
  logic                                have;
  ats_pkg::key_t                       best;
  ats_pkg::key_t                       last_key;

  // One table read port, addressed by the current step.
  logic [ats_pkg::TASK_BITS-1:0]       rd_addr;
  logic [1:0]                          rd_state;
  logic [ats_pkg::PRI_BITS-1:0]        rd_pri;
  logic [ats_pkg::PRI_BITS-1:0]        rd_rej;
  logic [ats_pkg::EPOCH_BITS-1:0]      rd_ep;
  logic [ats_pkg::EPOCH_BITS-1:0]      rd_tot;
  logic [ats_pkg::MAX_THREADS-1:0]     rd_mask;
  logic [ats_pkg::TASK_BITS-1:0]       rd_fifo;

  always_comb begin
    case (state)
      S_EXEC:  rd_addr = id_r;
      S_EMIT:  rd_addr = res_id;
      default: rd_addr = scan_i[ats_pkg::TASK_BITS-1:0];
    endcase
  end

  assign rd_state = ts_tab[rd_addr];
  assign rd_pri   = pri_tab[rd_addr];
  assign rd_rej   = rej_tab[rd_addr];
  assign rd_ep    = ep_tab[rd_addr];
  assign rd_tot   = tot_tab[rd_addr];
  assign rd_mask  = mask_tab[rd_addr];
  assign rd_fifo  = fifo[scan_i[ats_pkg::TASK_BITS-1:0]];

  // Update values for the single-task commands.
  logic [ats_pkg::PRI_BITS-1:0]    pri_inc;
  logic [ats_pkg::PRI_BITS-1:0]    rej_inc;
  logic [ats_pkg::MAX_THREADS-1:0] tid_bit;
  logic [ats_pkg::MAX_THREADS-1:0] mask_clr;
  logic [ats_pkg::EPOCH_BITS-1:0]  ep_next;
  logic                            fin_now;
  logic                            id_known;

  assign pri_inc  = (rd_pri == ats_pkg::PRI_MAX) ? rd_pri : rd_pri + 1'b1;
  assign rej_inc  = (rd_rej == ats_pkg::PRI_MAX) ? rd_rej : rd_rej + 1'b1;
  assign tid_bit  = {{(ats_pkg::MAX_THREADS-1){1'b0}}, 1'b1} << tid_r;
  assign mask_clr = rd_mask & ~tid_bit;
  assign ep_next  = rd_ep + 1'b1;
  assign fin_now  = (ep_next == rd_tot);
  assign id_known = ({1'b0, id_r} < tasks_added);

  // Shared comparator for the ready-list selection.
  ats_pkg::sel_ctrl_t sel_ctrl;
  ats_pkg::key_t      cand;
  logic               take;

  assign sel_ctrl.eligible = (rd_state == ats_pkg::TS_READY);
  assign sel_ctrl.first    = first;
  assign sel_ctrl.have     = have;
  assign cand              = {rd_pri, ~scan_i[ats_pkg::TASK_BITS-1:0]};

  ats_key_sel u_sel (
    .ctrl     (sel_ctrl),
    .cand     (cand),
    .last_key (last_key),
    .best     (best),
    .take     (take)
  );

  logic emit_go;

  assign in_stall = (state != S_IDLE);

  // A result item is loaded when the output register is free or being taken.
  assign emit_go  = (state == S_EMIT) && (!out_valid || !out_stall);

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      threshold <= ats_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      threshold <= cfg_wdata;
    end
  end

  // Sequencer and tables.
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      tasks_added <= '0;
      unfinished  <= '0;
      fifo_cnt    <= '0;
      in_fifo     <= '0;
      out_valid   <= 1'b0;
    end else begin
      if (emit_go) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            cmd_r <= in_item.cmd;
            id_r  <= in_item.task_id;
            tid_r <= in_item.thread_id;
            tot_r <= in_item.total_epochs;
            state <= S_EXEC;
          end
        end
        S_EXEC: begin
          res_last  <= 1'b1;
          list_mode <= 1'b0;
          if (cmd_r == ats_pkg::CMD_ADD) begin
            state <= S_EMIT;
            if (tasks_added == ats_pkg::COUNT_BITS'(ats_pkg::MAX_TASKS)) begin
              res_valid <= 1'b0;
              res_id    <= '0;
            end else begin
              ts_tab[tasks_added[ats_pkg::TASK_BITS-1:0]]   <= ats_pkg::TS_READY;
              pri_tab[tasks_added[ats_pkg::TASK_BITS-1:0]]  <= '0;
              rej_tab[tasks_added[ats_pkg::TASK_BITS-1:0]]  <= '0;
              ep_tab[tasks_added[ats_pkg::TASK_BITS-1:0]]   <= '0;
              tot_tab[tasks_added[ats_pkg::TASK_BITS-1:0]]  <= tot_r;
              mask_tab[tasks_added[ats_pkg::TASK_BITS-1:0]] <= '0;
              in_fifo[tasks_added[ats_pkg::TASK_BITS-1:0]]  <= 1'b0;
              res_valid   <= 1'b1;
              res_id      <= tasks_added[ats_pkg::TASK_BITS-1:0];
              tasks_added <= tasks_added + 1'b1;
              unfinished  <= unfinished + 1'b1;
            end
          end else if (cmd_r == ats_pkg::CMD_LIST) begin
            if (tasks_added == '0) begin
              res_valid <= 1'b0;
              res_id    <= '0;
              state     <= S_EMIT;
            end else begin
              scan_i    <= '0;
              ready_cnt <= '0;
              state     <= S_COUNT;
            end
          end else if (cmd_r > ats_pkg::CMD_LIST) begin
            res_valid <= 1'b0;
            res_id    <= '0;
            state     <= S_EMIT;
          end else if (!id_known) begin
            res_valid <= 1'b0;
            res_id    <= id_r;
            state     <= S_EMIT;
          end else begin
            res_valid <= 1'b1;
            res_id    <= id_r;
            state     <= (cmd_r == ats_pkg::CMD_DISP_OK && in_fifo[id_r]) ? S_FIFO : S_EMIT;
            case (cmd_r)
              ats_pkg::CMD_DISP_OK: begin
                ts_tab[id_r]  <= ats_pkg::TS_RUNNING;
                pri_tab[id_r] <= '0;
                rej_tab[id_r] <= '0;
                if (rd_state == ats_pkg::TS_FINISHED) begin
                  unfinished <= unfinished + 1'b1;
                end
                if (in_fifo[id_r]) begin
                  in_fifo[id_r] <= 1'b0;
                  scan_i        <= '0;
                  found         <= 1'b0;
                end
              end
              ats_pkg::CMD_DISP_FAIL: begin
                pri_tab[id_r] <= pri_inc;
                rej_tab[id_r] <= rej_inc;
                if (pri_inc >= threshold && !in_fifo[id_r]) begin
                  fifo[fifo_cnt[ats_pkg::TASK_BITS-1:0]] <= id_r;
                  if (fifo_cnt == '0) begin
                    head <= id_r;
                  end
                  fifo_cnt      <= fifo_cnt + 1'b1;
                  in_fifo[id_r] <= 1'b1;
                  ts_tab[id_r]  <= ats_pkg::TS_STARVED;
                  if (rd_state == ats_pkg::TS_FINISHED) begin
                    unfinished <= unfinished + 1'b1;
                  end
                end
              end
              ats_pkg::CMD_TRACK: begin
                mask_tab[id_r] <= rd_mask | tid_bit;
              end
              ats_pkg::CMD_FINISH: begin
                mask_tab[id_r] <= mask_clr;
                if (mask_clr == '0) begin
                  ep_tab[id_r] <= ep_next;
                  ts_tab[id_r] <= fin_now ? ats_pkg::TS_FINISHED : ats_pkg::TS_READY;
                  if (fin_now && rd_state != ats_pkg::TS_FINISHED) begin
                    unfinished <= unfinished - 1'b1;
                  end else if (!fin_now && rd_state == ats_pkg::TS_FINISHED) begin
                    unfinished <= unfinished + 1'b1;
                  end
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_FIFO: begin
          // Walk the starved list, closing the gap left by the removed task.
          if (found) begin
            fifo[scan_i[ats_pkg::TASK_BITS-1:0] - ats_pkg::TASK_BITS'(1)] <= rd_fifo;
            if (scan_i == ats_pkg::COUNT_BITS'(1)) begin
              head <= rd_fifo;
            end
          end
          if (rd_fifo == id_r) begin
            found <= 1'b1;
          end
          if (scan_i == fifo_cnt - 1'b1) begin
            fifo_cnt <= fifo_cnt - 1'b1;
            state    <= S_EMIT;
          end else begin
            scan_i <= scan_i + 1'b1;
          end
        end
        S_COUNT: begin
          // Count ready tasks so the final listed item can be marked.
          if (scan_i == tasks_added) begin
            if (ready_cnt == '0) begin
              res_valid <= 1'b0;
              res_id    <= '0;
              state     <= S_EMIT;
            end else begin
              scan_i <= '0;
              first  <= 1'b1;
              have   <= 1'b0;
              state  <= S_SCAN;
            end
          end else begin
            if (rd_state == ats_pkg::TS_READY) begin
              ready_cnt <= ready_cnt + 1'b1;
            end
            scan_i <= scan_i + 1'b1;
          end
        end
        S_SCAN: begin
          // Find the next ready task in priority order.
          if (scan_i == tasks_added) begin
            res_id    <= ~best[ats_pkg::TASK_BITS-1:0];
            res_valid <= 1'b1;
            res_last  <= (ready_cnt == ats_pkg::COUNT_BITS'(1));
            list_mode <= 1'b1;
            state     <= S_EMIT;
          end else begin
            if (take) begin
              best <= cand;
              have <= 1'b1;
            end
            scan_i <= scan_i + 1'b1;
          end
        end
        S_EMIT: begin
          if (emit_go) begin
            out_item.result_task     <= res_id;
            out_item.task_state      <= res_valid ? rd_state : 2'd0;
            out_item.priority_now    <= res_valid ? rd_pri : '0;
            out_item.rejections_now  <= res_valid ? rd_rej : '0;
            out_item.all_done        <= (unfinished == '0);
            out_item.starved_present <= (fifo_cnt != '0);
            out_item.starved_head    <= (fifo_cnt != '0) ? head : '0;
            out_item.entry_valid     <= res_valid;
            out_item.last            <= res_last;
            if (list_mode && !res_last) begin
              last_key  <= best;
              first     <= 1'b0;
              have      <= 1'b0;
              ready_cnt <= ready_cnt - 1'b1;
              scan_i    <= '0;
              state     <= S_SCAN;
            end else begin
              state <= S_IDLE;
            end
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

`ifndef NO_ASSERTIONS
  a_fifo_bound: assert property (@(posedge clk) disable iff (rst)
    fifo_cnt <= ats_pkg::COUNT_BITS'(ats_pkg::MAX_TASKS))
    else $error("starved list count beyond table size");

  a_unfinished_bound: assert property (@(posedge clk) disable iff (rst)
    unfinished <= tasks_added)
    else $error("unfinished count beyond tasks added");

  a_list_progress: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN && scan_i == tasks_added) |-> have)
    else $error("list pass found no ready task");
`endif

endmodule

// ===== src/ats_key_sel.sv =====
module ats_key_sel (
  input  ats_pkg::sel_ctrl_t ctrl,
  input  ats_pkg::key_t      cand,
  input  ats_pkg::key_t      last_key,
  input  ats_pkg::key_t      best,
  output logic               take
);

  logic below;

  // A candidate must rank after the last listed task and beat the best so far.
  assign below = ctrl.first || (cand < last_key);
  assign take  = ctrl.eligible && below && (!ctrl.have || (cand > best));

endmodule
